[rtl/centroid_slope_sign_features_assert.svh]
// assertion macros shared by the centroid slope sign feature block
`ifndef CENTROID_SLOPE_SIGN_FEATURES_ASSERT_SVH
`define CENTROID_SLOPE_SIGN_FEATURES_ASSERT_SVH

`ifndef SYNTH
// check a property on every clock edge outside reset
`define CSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define CSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSF_ASSERT(lbl, prop, msg)
`define CSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/csf_pkg.sv]
// shared types and constants for the centroid slope sign feature block
`default_nettype none

package csf_pkg;

  // fixed field widths
  localparam int SPACING_W = 11;
  localparam int OP_W      = 2;
  localparam int FEAT_W    = 3;
  localparam int PIDX_W    = 10;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W  = OUT_DATA_W - PIDX_W - FEAT_W;

  // parameter defaults
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;

  // feature codes
  localparam logic signed [FEAT_W-1:0] FEAT_NEG  = -3'sd1;
  localparam logic signed [FEAT_W-1:0] FEAT_ZERO = 3'sd0;
  localparam logic signed [FEAT_W-1:0] FEAT_POS  = 3'sd1;
  localparam logic signed [FEAT_W-1:0] FEAT_VERT = 3'sd2;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_FETCH = 2'd1,
    OP_CLEAR = 2'd2
  } csf_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear;
    logic div_start;
    logic mul;
    logic res_hit;
    logic res_none;
  } csf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stale;
    logic div_busy;
    logic past_end;
    logic out_free;
  } csf_stat_t;

endpackage

`default_nettype wire

[rtl/csf_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module csf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/csf_ctrl.sv]
// controller state machine sequencing load, clear and fetch requests
`default_nettype none

module csf_ctrl
  import csf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic [OP_W-1:0] opcode,
  output logic                 s_tready,
  input  wire csf_stat_t       st,
  output csf_cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_CHECK = 5'b00100,
    S_READ  = 5'b01000,
    S_CMP   = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (csf_op_t'(opcode))
            OP_LOAD:  cmd.load  = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            OP_FETCH: begin
              if (st.stale) begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
              end else begin
                state_next = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // read address is presented here; exhausted stroke answers once the output is free
        if (st.past_end) begin
          if (st.out_free) begin
            cmd.res_none = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mul    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.out_free) begin
          cmd.res_hit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/csf_dp.sv]
// datapath: point stores, running sums, sample pointer, remainder unit, compare
`default_nettype none

module csf_dp
  import csf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic [SPACING_W-1:0]     cfg_wr_data,
  input  wire logic [COORD_BITS-1:0]    x_coord,
  input  wire logic [COORD_BITS-1:0]    y_coord,
  input  wire csf_cmd_t                 cmd,
  output csf_stat_t                     st,
  input  wire logic                     m_tready,
  output logic                          m_tvalid,
  output logic signed [FEAT_W-1:0]      feature,
  output logic [PIDX_W-1:0]             point_index,
  output logic                          last_feature,
  output logic                          none_left
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = CNT_W + COORD_BITS;
  localparam int NXT_W  = ((CNT_W > SPACING_W) ? CNT_W : SPACING_W) + 1;
  localparam int DIV_W  = $clog2(MAX_POINTS + 2);
  localparam int DCNT_W = $clog2(DIV_W + 1);

  logic [SPACING_W-1:0]  spacing;
  logic [SPACING_W-1:0]  n_eff;
  logic [CNT_W-1:0]      point_count;
  logic [SUM_W-1:0]      x_sum, y_sum;
  logic [CNT_W-1:0]      fetch_index;
  logic [NXT_W-1:0]      next_idx;
  logic                  stale;
  logic                  store_we;
  logic [COORD_BITS-1:0] x_rd, y_rd;
  logic [SUM_W-1:0]      prod_x, prod_y;
  logic [DCNT_W-1:0]     div_cnt;
  logic [DIV_W-1:0]      div_q;
  logic [SPACING_W-1:0]  div_r;
  logic [SPACING_W:0]    div_t;
  logic [SPACING_W-1:0]  div_r_next;
  logic [NXT_W-1:0]      div_idx;
  logic [NXT_W-1:0]      nxt_after;
  logic                  x_gt, x_eq, y_gt, y_eq;
  logic signed [FEAT_W-1:0] feat_calc;

  // zero spacing samples like spacing one
  assign n_eff    = (spacing == '0) ? SPACING_W'(1) : spacing;
  assign store_we = cmd.load && (point_count < CNT_W'(MAX_POINTS));

  // coordinate stores
  csf_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata (x_coord),
    .raddr (next_idx[IDX_W-1:0]),
    .rdata (x_rd)
  );

  csf_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (point_count[IDX_W-1:0]),
    .wdata (y_coord),
    .raddr (next_idx[IDX_W-1:0]),
    .rdata (y_rd)
  );

  // restoring remainder step: (fetch_index + 1) mod n, one bit a cycle
  assign div_t = {div_r, div_q[DIV_W-1]};
  always_comb begin
    if (div_t >= {1'b0, n_eff}) begin
      div_r_next = SPACING_W'(div_t - {1'b0, n_eff});
    end else begin
      div_r_next = div_t[SPACING_W-1:0];
    end
  end

  // round fetch_index up to the next sampled index once the remainder is known
  always_comb begin
    if (div_r_next == '0) begin
      div_idx = NXT_W'(fetch_index);
    end else begin
      div_idx = NXT_W'(fetch_index) + NXT_W'(n_eff) - NXT_W'(div_r_next);
    end
  end

  // sampled index that follows the one being reported
  always_comb begin
    if (next_idx == '0 && n_eff != SPACING_W'(1)) begin
      nxt_after = NXT_W'(n_eff) - NXT_W'(1);
    end else begin
      nxt_after = next_idx + NXT_W'(n_eff);
    end
  end

  // centroid compare: count * coord against the coordinate sum
  assign x_gt = x_sum > prod_x;
  assign x_eq = x_sum == prod_x;
  assign y_gt = y_sum > prod_y;
  assign y_eq = y_sum == prod_y;

  always_comb begin
    if (x_eq) begin
      feat_calc = FEAT_VERT;
    end else if (y_eq) begin
      feat_calc = FEAT_ZERO;
    end else if (x_gt == y_gt) begin
      feat_calc = FEAT_POS;
    end else begin
      feat_calc = FEAT_NEG;
    end
  end

  // stroke state, sample pointer and remainder control
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing     <= SPACING_W'(1);
      point_count <= '0;
      x_sum       <= '0;
      y_sum       <= '0;
      fetch_index <= '0;
      next_idx    <= '0;
      stale       <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (cfg_wr_en) begin
        spacing <= cfg_wr_data;
        stale   <= 1'b1;
      end
      if (cmd.clear) begin
        point_count <= '0;
        x_sum       <= '0;
        y_sum       <= '0;
        fetch_index <= '0;
        next_idx    <= '0;
        stale       <= 1'b0;
      end else if (store_we) begin
        point_count <= point_count + CNT_W'(1);
        x_sum       <= x_sum + SUM_W'(x_coord);
        y_sum       <= y_sum + SUM_W'(y_coord);
      end
      if (cmd.div_start) begin
        div_cnt <= DCNT_W'(DIV_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - DCNT_W'(1);
        if (div_cnt == DCNT_W'(1)) begin
          next_idx <= div_idx;
          stale    <= 1'b0;
        end
      end
      if (cmd.res_hit) begin
        fetch_index <= next_idx[CNT_W-1:0] + CNT_W'(1);
        next_idx    <= nxt_after;
      end
    end
  end

  // remainder datapath
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q <= DIV_W'(fetch_index) + DIV_W'(1);
      div_r <= '0;
    end else if (div_cnt != '0) begin
      div_q <= {div_q[DIV_W-2:0], 1'b0};
      div_r <= div_r_next;
    end
  end

  // products of count and the sampled coordinates
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x <= SUM_W'(point_count) * SUM_W'(x_rd);
      prod_y <= SUM_W'(point_count) * SUM_W'(y_rd);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_hit || cmd.res_none) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.res_hit) begin
      feature      <= feat_calc;
      point_index  <= next_idx[PIDX_W-1:0];
      last_feature <= nxt_after >= NXT_W'(point_count);
      none_left    <= 1'b0;
    end else if (cmd.res_none) begin
      feature      <= FEAT_ZERO;
      point_index  <= '0;
      last_feature <= 1'b1;
      none_left    <= 1'b1;
    end
  end

  // status to the controller
  assign st.stale    = stale && (fetch_index != '0);
  assign st.div_busy = div_cnt != '0;
  assign st.past_end = next_idx >= NXT_W'(point_count);
  assign st.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

[rtl/centroid_slope_sign_features.sv]
// Load and clear requests are taken in idle; the block stays ready for the next request.
// A hit fetch steps through accept, check and store read, multiply and compare, and
// registers its result from the compare; an empty or exhausted fetch answers from check.
// Results wait while the output register is held; a fetch past index 0 after a spacing
// write first runs the remainder unit before the check.
// Reset is synchronous: spacing 1, stroke empty, point stores not cleared.
`default_nettype none
`include "centroid_slope_sign_features_assert.svh"

module centroid_slope_sign_features
  import csf_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [SPACING_W-1:0]  cfg_wr_data,  // segment_spacing
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,      // x_coord, y_coord, zero pad
  input  wire logic [OP_W-1:0]       s_tuser,      // opcode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,      // feature, point_index, zero pad
  output logic                       m_tlast,      // last_feature
  output logic                       m_tuser       // none_left
);

  csf_cmd_t                 cmd;
  csf_stat_t                st;
  logic signed [FEAT_W-1:0] feature;
  logic [PIDX_W-1:0]        point_index;

  // request sequencing
  csf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // stores, sums and feature compare
  csf_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .x_coord      (s_tdata[COORD_BITS-1:0]),
    .y_coord      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cmd          (cmd),
    .st           (st),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .feature      (feature),
    .point_index  (point_index),
    .last_feature (m_tlast),
    .none_left    (m_tuser)
  );

  // result packing
  assign m_tdata = {{OUT_PAD_W{1'b0}}, point_index, feature};

  // checks
  `CSF_ASSERT(a_ready_not_dividing, s_tready |-> !st.div_busy, "ready while remainder busy")
  `CSF_ASSERT(a_result_into_free_reg, (cmd.res_hit || cmd.res_none) |-> st.out_free, "output busy")
  `CSF_ASSERT(a_div_runs, cmd.div_start |=> st.div_busy, "remainder unit did not start")
  `CSF_ASSERT(a_none_is_last, (m_tvalid && m_tuser) |-> m_tlast, "empty result not marked last")

endmodule

`default_nettype wire

[dv/tb_centroid_slope_sign_features.sv]
// testbench for the centroid slope sign feature block: directed table, random strokes, self-check
`timescale 1ns / 1ps
`default_nettype none

module tb_centroid_slope_sign_features;
  import csf_pkg::*;

  localparam int CW           = COORD_BITS_DEF;
  localparam int STORE_DEPTH  = MAX_POINTS_DEF;
  localparam int ITEM_TARGET  = 1900;
  localparam int SETTLE       = 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one fetch result as the block reports it
  typedef struct packed {
    logic signed [FEAT_W-1:0] slope_sign;
    logic [PIDX_W-1:0]        pidx;
    logic                     last_feat;
    logic                     none_left;
  } feature_t;

  // one row of the directed table
  typedef struct {
    logic [OP_W-1:0] op;
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
    bit              fixed;
    feature_t        want;
  } stim_row_t;

  localparam feature_t NOTHING_LEFT = '{FEAT_ZERO, '0, 1'b1, 1'b1};
  localparam feature_t LONE_POINT   = '{FEAT_VERT, '0, 1'b1, 1'b0};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [SPACING_W-1:0] cfg_wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [2*CW-1:0]      s_tdata = '0;     // x_coord, y_coord
  logic [OP_W-1:0]      s_tuser = '0;     // opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // feature, point_index, zero pad
  logic                 m_tlast;          // last_feature
  logic                 m_tuser;          // none_left

  // stroke predictor state
  logic [CW-1:0]        x_mem [STORE_DEPTH];
  logic [CW-1:0]        y_mem [STORE_DEPTH];
  logic [10:0]          pt_count = '0;
  logic [25:0]          x_sum = '0;
  logic [25:0]          y_sum = '0;
  logic [10:0]          fetch_ptr = '0;
  logic [SPACING_W-1:0] spacing_q = 11'd1;

  feature_t  feature_q[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        stall_left = 0;
  bit        steady = 1'b0;

  centroid_slope_sign_features u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, feature_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // smallest sampled index at or above from
  function automatic int sample_at(int from);
    int n;
    n = (spacing_q == 0) ? 1 : int'(spacing_q);
    if (from == 0) return 0;
    return ((from + n) / n) * n - 1;
  endfunction

  // update the stroke for one request and work out its result, if any
  task automatic predict_request(input logic [OP_W-1:0] op, input logic [CW-1:0] x,
                                 input logic [CW-1:0] y, output bit has_res,
                                 output feature_t res);
    int     idx;
    longint dx;
    longint dy;
    has_res = 1'b0;
    res = '0;
    case (op)
      OP_LOAD: begin
        if (pt_count < STORE_DEPTH) begin
          x_mem[pt_count[9:0]] = x;
          y_mem[pt_count[9:0]] = y;
          x_sum = x_sum + x;
          y_sum = y_sum + y;
          pt_count = pt_count + 11'd1;
        end
      end
      OP_CLEAR: begin
        pt_count = '0;
        x_sum = '0;
        y_sum = '0;
        fetch_ptr = '0;
      end
      OP_FETCH: begin
        has_res = 1'b1;
        idx = sample_at(int'(fetch_ptr));
        if (idx >= int'(pt_count)) begin
          res = NOTHING_LEFT;
        end else begin
          dx = longint'(x_sum) - longint'(pt_count) * longint'(x_mem[idx]);
          dy = longint'(y_sum) - longint'(pt_count) * longint'(y_mem[idx]);
          if (dx == 0) res.slope_sign = FEAT_VERT;
          else if (dy == 0) res.slope_sign = FEAT_ZERO;
          else if ((dx > 0) == (dy > 0)) res.slope_sign = FEAT_POS;
          else res.slope_sign = FEAT_NEG;
          res.pidx = idx[PIDX_W-1:0];
          res.last_feat = (sample_at(idx + 1) >= int'(pt_count));
          fetch_ptr = 11'(idx + 1);
        end
      end
      default: ;
    endcase
  endtask

  // hand one request over, then predict it
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CW-1:0] x,
                              input logic [CW-1:0] y, input bit fixed = 1'b0,
                              input feature_t want = '0);
    int       gap;
    bit       has_res;
    feature_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {y, x};
    do @(posedge clk); while (!s_tready);
    predict_request(op, x, y, has_res, res);
    if (has_res) feature_q.push_back(fixed ? want : res);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (feature_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [SPACING_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    spacing_q = v;
  endtask

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [CW-1:0] x,
                                  input logic [CW-1:0] y, input bit fixed = 1'b0,
                                  input feature_t want = '0);
    stim_row_t row;
    row.op = op;
    row.x = x;
    row.y = y;
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // coordinate flavors: full range, extremes, tie-prone grid, tiny values
  function automatic logic [CW-1:0] pick_coord(input int mode);
    case (mode)
      0: return CW'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? '1 : '0;
      2: return CW'(5000 + 1000 * $urandom_range(0, 2));
      default: return CW'($urandom_range(0, 3));
    endcase
  endfunction

  // one stroke: mostly clear, loads, fetches to the end, with some noise
  task automatic run_stroke();
    int n_pts;
    int n_fetch;
    int mode;
    int eff;
    steady = ($urandom_range(0, 4) == 0);
    mode = $urandom_range(0, 3);
    n_pts = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
    eff = (spacing_q == 0) ? 1 : int'(spacing_q);
    if ($urandom_range(0, 9) != 0)
      send_request(OP_CLEAR, CW'($urandom), CW'($urandom));
    repeat (n_pts) begin
      if ($urandom_range(0, 19) == 0)
        send_request(OP_W'($urandom_range(0, 3)), CW'($urandom), CW'($urandom));
      send_request(OP_LOAD, pick_coord(mode), pick_coord(mode));
    end
    n_fetch = n_pts / eff + $urandom_range(1, 3);
    repeat (n_fetch) begin
      if ($urandom_range(0, 15) == 0)
        send_request(OP_LOAD, pick_coord(mode), pick_coord(mode));
      send_request(OP_FETCH, CW'($urandom), CW'($urandom));
    end
  endtask

  // output side: random stalls, with stretches of steady ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 2) == 0) begin
      stall_left = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin : result_check
    feature_t got;
    feature_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.slope_sign = m_tdata[FEAT_W-1:0];
      got.pidx = m_tdata[FEAT_W+PIDX_W-1:FEAT_W];
      got.last_feat = m_tlast;
      got.none_left = m_tuser;
      if (feature_q.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = feature_q.pop_front();
        check_field("feature", 32'(want.slope_sign), 32'(got.slope_sign));
        check_field("point_index", 32'(want.pidx), 32'(got.pidx));
        check_field("last_feature", 32'(want.last_feat), 32'(got.last_feat));
        check_field("none_left", 32'(want.none_left), 32'(got.none_left));
      end
    end
  end

  // main sequence
  initial begin
    int phase;
    int r;
    logic [SPACING_W-1:0] sp;

    // directed table at reset spacing
    add_row(OP_FETCH, '0, '0, 1'b1, NOTHING_LEFT);
    add_row(OP_UNUSED, '1, '1);
    add_row(OP_LOAD, '0, '0);
    add_row(OP_FETCH, '0, '0, 1'b1, LONE_POINT);
    add_row(OP_FETCH, '0, '0, 1'b1, NOTHING_LEFT);
    add_row(OP_CLEAR, '1, '1);
    add_row(OP_LOAD, '1, '0);
    add_row(OP_LOAD, '0, '1);
    add_row(OP_LOAD, '1, '1);
    add_row(OP_LOAD, '0, '0);
    repeat (4) add_row(OP_FETCH, '0, '0);
    add_row(OP_FETCH, '0, '0, 1'b1, NOTHING_LEFT);
    add_row(OP_LOAD, 16'd1234, 16'd0);
    add_row(OP_FETCH, '1, '1);
    add_row(OP_CLEAR, '0, '0);
    add_row(OP_FETCH, '0, '0, 1'b1, NOTHING_LEFT);
    add_row(OP_LOAD, 16'd100, 16'd50);
    add_row(OP_LOAD, 16'd200, 16'd50);
    add_row(OP_LOAD, 16'd150, 16'd90);
    repeat (3) add_row(OP_FETCH, '0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].fixed, directed_rows[i].want);

    // random phases, each at its own spacing
    for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
      drain();
      r = $urandom_range(0, 9);
      case (phase)
        0: sp = 11'd0;
        1: sp = 11'd2047;
        2: sp = 11'd1024;
        3: sp = 11'd1;
        default: begin
          if (r < 6) sp = SPACING_W'($urandom_range(1, 6));
          else if (r < 8) sp = SPACING_W'($urandom_range(7, 1024));
          else if (r == 8) sp = 11'd0;
          else sp = 11'd2047;
        end
      endcase
      write_spacing(sp);
      if (phase == 2) begin
        // fill the store past its end, then walk the first and last sampled points
        steady = 1'b0;
        send_request(OP_CLEAR, '0, '0);
        repeat (STORE_DEPTH + 6) send_request(OP_LOAD, pick_coord(0), pick_coord(0));
        repeat (4) send_request(OP_FETCH, '0, '0);
        send_request(OP_LOAD, '1, '1);
        send_request(OP_FETCH, '0, '0);
      end else begin
        repeat ($urandom_range(2, 5)) run_stroke();
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
